>>> design/melody_note_queue_player_macros.svh
// Assertion shorthands used by the checker file of the note queue player.
`ifndef MELODY_NOTE_QUEUE_PLAYER_MACROS_SVH
`define MELODY_NOTE_QUEUE_PLAYER_MACROS_SVH

// Same-cycle implication, off while in reset.
`define MNQP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define MNQP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mnqp_pkg.sv
package mnqp_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 32;

  // field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned FREQ_W  = 16;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned DIV_W   = 8;
  localparam int unsigned DUTY_W  = 6;
  localparam int unsigned QCNT_W  = 6;
  localparam int unsigned TEMPO_W = 9;
  localparam int unsigned ENTRY_W = FREQ_W + MS_W;

  // register port
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned REG_IDX_LSB = 2;
  localparam logic        REG_TEMPO   = 1'b0;
  localparam logic [TEMPO_W-1:0] TEMPO_RESET = 9'd100;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_RAW    = 2'd0,
    OP_ADD_SCORED = 2'd1,
    OP_TICK       = 2'd2
  } op_e;

  localparam logic [DUTY_W-1:0] DUTY_START = 6'd40;
  localparam logic [DUTY_W-1:0] FADE_START = 6'd39;

  // serial divider: whole note is 4 beats of 60000 ms
  localparam int unsigned WHOLE_W = 18;
  localparam int unsigned QUO_W   = WHOLE_W + 4;
  localparam int unsigned REM_W   = TEMPO_W;
  localparam int unsigned CNT_W   = $clog2(QUO_W);
  localparam logic [WHOLE_W-1:0] WHOLE_NOTE_MS = 18'd240000;
  localparam logic [REM_W-1:0]   SCALE_DEN     = 9'd10;
  localparam logic [CNT_W-1:0]   ITER_WHOLE    = CNT_W'(WHOLE_W - 1);
  localparam logic [CNT_W-1:0]   ITER_FULL     = CNT_W'(QUO_W - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV_W = 5'b00010,
    S_DIV_N = 5'b00100,
    S_DIV_S = 5'b01000,
    S_APPLY = 5'b10000
  } state_e;

endpackage

>>> design/melody_note_queue_player.sv
// Buzzer tone sequencer with a ring queue of notes. Each input transfer is a raw add, a scored
// add (duration from the tempo register and a note divider, negative for dotted notes, scaled
// by 9/10) or a one-millisecond tick, and each gives one result transfer with the accept flag
// and the frequency, duty, playing flag and queue fill after it. Raw adds, ticks, unused
// codes and scored adds with a zero divider go straight to the apply step. A scored add with a
// nonzero divider first runs one bit-serial restoring divider that yields one quotient bit per
// cycle over three passes of 18, 18 and 22 bits (whole note by tempo, by the divider, then 9x
// by ten). Queue entries are read from a memory with a registered read port. A stalled result
// holds the next item in its apply step, and the input side stays stalled until it is applied.
module melody_note_queue_player #(
  parameter int unsigned QUEUE_DEPTH = mnqp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mnqp_pkg::OP_W-1:0]           operation_i,
  input  logic [mnqp_pkg::FREQ_W-1:0]         tone_frequency_in_i,
  input  logic [mnqp_pkg::MS_W-1:0]           duration_ms_in_i,
  input  logic signed [mnqp_pkg::DIV_W-1:0]   score_divider_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                accepted_o,
  output logic [mnqp_pkg::FREQ_W-1:0]         tone_frequency_out_o,
  output logic [mnqp_pkg::DUTY_W-1:0]         pwm_duty_o,
  output logic                                playing_o,
  output logic [mnqp_pkg::QCNT_W-1:0]         queued_count_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mnqp_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mnqp_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mnqp_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import mnqp_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  // register port
  logic [TEMPO_W-1:0] tempo_q;
  logic               tempo_sel;
  logic               tempo_wr;

  assign pready    = 1'b1;
  assign tempo_sel = (paddr[APB_ADDR_W-1:REG_IDX_LSB] == REG_TEMPO);
  assign tempo_wr  = psel & penable & pwrite & pready & tempo_sel;
  assign prdata    = tempo_sel ? APB_DATA_W'(tempo_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q <= TEMPO_RESET;
    end else if (tempo_wr) begin
      tempo_q <= pwdata[TEMPO_W-1:0];
    end
  end

  // control
  state_e state_q, state_d;
  logic   in_fire;
  logic   out_free;
  logic   apply_fire;
  logic   out_valid_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign apply_fire = (state_q == S_APPLY) & out_free;

  // item and divider datapath
  logic [OP_W-1:0]    op_q;
  logic [FREQ_W-1:0]  freq_q;
  logic [DIV_W-1:0]   div_q;
  logic [MS_W-1:0]    dur_q;
  logic [QUO_W-1:0]   quo_q;
  logic [REM_W-1:0]   rem_q;
  logic [REM_W-1:0]   dvs_q;
  logic [CNT_W-1:0]   cnt_q;

  logic [REM_W:0]     rem_sh;
  logic [REM_W:0]     rem_sub;
  logic               rem_ge;
  logic [REM_W-1:0]   rem_step;
  logic [QUO_W-1:0]   quo_step;
  logic [DIV_W-1:0]   mag;
  logic [WHOLE_W-1:0] n_val;
  logic [WHOLE_W:0]   n_dot;
  logic [QUO_W-1:0]   n_nine;
  logic [MS_W-1:0]    dur_sat;
  logic               div_busy;

  assign rem_sh   = {rem_q, quo_q[QUO_W-1]};
  assign rem_sub  = rem_sh - {1'b0, dvs_q};
  assign rem_ge   = (rem_sh >= {1'b0, dvs_q});
  assign rem_step = rem_ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
  assign quo_step = {quo_q[QUO_W-2:0], rem_ge};

  assign mag      = div_q[DIV_W-1] ? (~div_q + 1'b1) : div_q;
  assign n_val    = quo_step[WHOLE_W-1:0];
  // dotted note adds half its value
  assign n_dot    = {1'b0, n_val} + (div_q[DIV_W-1] ? {2'b00, n_val[WHOLE_W-1:1]} : '0);
  assign n_nine   = {n_dot, 3'b000} + QUO_W'(n_dot);
  assign dur_sat  = (|quo_step[QUO_W-1:MS_W]) ? '1 : quo_step[MS_W-1:0];
  assign div_busy = (state_q == S_DIV_W) | (state_q == S_DIV_N) | (state_q == S_DIV_S);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= operation_i;
      freq_q <= tone_frequency_in_i;
      div_q  <= $unsigned(score_divider_i);
      dur_q  <= (operation_i == OP_ADD_SCORED) ? '0 : duration_ms_in_i;
      quo_q  <= {WHOLE_NOTE_MS, {(QUO_W - WHOLE_W){1'b0}}};
      rem_q  <= '0;
      dvs_q  <= (tempo_q == '0) ? REM_W'(1) : tempo_q;
      cnt_q  <= ITER_WHOLE;
    end else if (div_busy) begin
      if (cnt_q != '0) begin
        quo_q <= quo_step;
        rem_q <= rem_step;
        cnt_q <= cnt_q - 1'b1;
      end else if (state_q == S_DIV_W) begin
        quo_q <= {quo_step[WHOLE_W-1:0], {(QUO_W - WHOLE_W){1'b0}}};
        rem_q <= '0;
        dvs_q <= REM_W'(mag);
        cnt_q <= ITER_WHOLE;
      end else if (state_q == S_DIV_N) begin
        quo_q <= n_nine;
        rem_q <= '0;
        dvs_q <= SCALE_DEN;
        cnt_q <= ITER_FULL;
      end else begin
        dur_q <= dur_sat;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if ((operation_i == OP_ADD_SCORED) && (score_divider_i != '0)) begin
            state_d = S_DIV_W;
          end else begin
            state_d = S_APPLY;
          end
        end
      end
      S_DIV_W: begin
        if (cnt_q == '0) state_d = S_DIV_N;
      end
      S_DIV_N: begin
        if (cnt_q == '0) state_d = S_DIV_S;
      end
      S_DIV_S: begin
        if (cnt_q == '0) state_d = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (apply_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // player state
  logic              playing_q, playing_d;
  logic [MS_W-1:0]   rem_ms_q, rem_ms_d;
  logic [DUTY_W-1:0] fade_q, fade_d;
  logic [DUTY_W-1:0] duty_q, duty_d;
  logic [FREQ_W-1:0] freq_now_q, freq_now_d;
  logic [AW-1:0]     head_q, head_d;
  logic [AW-1:0]     tail_q, tail_d;
  logic [CW-1:0]     count_q, count_d;
  logic              accepted_q;
  logic              ok;
  logic              push;
  logic              start_note;
  logic [FREQ_W-1:0] start_freq;
  logic [MS_W-1:0]   start_ms;

  logic [ENTRY_W-1:0] note_mem_q [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_entry_q;

  always_comb begin
    playing_d  = playing_q;
    rem_ms_d   = rem_ms_q;
    fade_d     = fade_q;
    duty_d     = duty_q;
    freq_now_d = freq_now_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    ok         = 1'b0;
    push       = 1'b0;
    start_note = 1'b0;
    start_freq = freq_q;
    start_ms   = dur_q;
    unique case (op_q)
      OP_ADD_RAW, OP_ADD_SCORED: begin
        if (playing_q) begin
          if (count_q != FULL_CNT) begin
            push    = 1'b1;
            tail_d  = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
            count_d = count_q + 1'b1;
            ok      = 1'b1;
          end
        end else begin
          start_note = 1'b1;
          playing_d  = 1'b1;
          ok         = 1'b1;
        end
      end
      OP_TICK: begin
        ok = 1'b1;
        if (playing_q) begin
          if (rem_ms_q > MS_W'(1)) begin
            rem_ms_d = rem_ms_q - 1'b1;
            // fade down, stop at one
            if (fade_q > DUTY_W'(1)) begin
              duty_d = fade_q;
              fade_d = fade_q - 1'b1;
            end
          end else begin
            duty_d    = '0;
            rem_ms_d  = '0;
            playing_d = 1'b0;
            if (count_q != '0) begin
              head_d     = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
              count_d    = count_q - 1'b1;
              start_note = 1'b1;
              start_freq = rd_entry_q[ENTRY_W-1:MS_W];
              start_ms   = rd_entry_q[MS_W-1:0];
              playing_d  = 1'b1;
            end
          end
        end
      end
      default: ok = 1'b0;
    endcase
    if (start_note) begin
      if (start_freq != '0) begin
        freq_now_d = start_freq;
        duty_d     = DUTY_START;
        fade_d     = FADE_START;
      end else begin
        // rest: silence, keep the last frequency
        duty_d = '0;
        fade_d = '0;
      end
      rem_ms_d = start_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q  <= 1'b0;
      rem_ms_q   <= '0;
      fade_q     <= '0;
      duty_q     <= '0;
      freq_now_q <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
    end else if (apply_fire) begin
      playing_q  <= playing_d;
      rem_ms_q   <= rem_ms_d;
      fade_q     <= fade_d;
      duty_q     <= duty_d;
      freq_now_q <= freq_now_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_fire) begin
      accepted_q <= ok;
    end
  end

  // note memory, registered read of the head entry
  always_ff @(posedge clk_i) begin
    if (apply_fire && push) begin
      note_mem_q[tail_q] <= {freq_q, dur_q};
    end
    rd_entry_q <= note_mem_q[head_q];
  end

  // player state only moves when the result slot advances, so it drives the result directly
  assign out_valid_o          = out_valid_q;
  assign accepted_o           = accepted_q;
  assign tone_frequency_out_o = freq_now_q;
  assign pwm_duty_o           = duty_q;
  assign playing_o            = playing_q;
  assign queued_count_o       = QCNT_W'(count_q);

endmodule

>>> design/mnqp_checker.sv
`include "melody_note_queue_player_macros.svh"

module mnqp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic                                accepted_o,
  input logic [mnqp_pkg::FREQ_W-1:0]         tone_frequency_out_o,
  input logic [mnqp_pkg::DUTY_W-1:0]         pwm_duty_o,
  input logic                                playing_o,
  input logic [mnqp_pkg::QCNT_W-1:0]         queued_count_o
);
  import mnqp_pkg::*;

  `MNQP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(accepted_o) && $stable(tone_frequency_out_o) && $stable(pwm_duty_o) && $stable(playing_o) && $stable(queued_count_o),
    "stalled result changed")

  `MNQP_ASSERT_NOW(a_idle_silent, clk_i, rst_ni, out_valid_o && !playing_o,
    (pwm_duty_o == '0) && (queued_count_o == '0),
    "idle player shows duty or queued notes")

  `MNQP_ASSERT_NOW(a_duty_tone, clk_i, rst_ni, out_valid_o && (pwm_duty_o != '0),
    (tone_frequency_out_o != '0) && (pwm_duty_o <= DUTY_START),
    "duty without a tone or above start level")

  `MNQP_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o,
    in_stall_o,
    "input taken again before item finished")

endmodule

bind melody_note_queue_player mnqp_checker u_mnqp_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_stall_o           (in_stall_o),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .accepted_o           (accepted_o),
  .tone_frequency_out_o (tone_frequency_out_o),
  .pwm_duty_o           (pwm_duty_o),
  .playing_o            (playing_o),
  .queued_count_o       (queued_count_o)
);
